// ===== hw/rtl/epid_pkg.sv =====
// Shared types and constants for the individual-based SIR epidemic step block.
// Holds field widths, status and function codes, register indexes and reset values.
// No dependencies.
package epid_pkg;

  localparam int MAX_PEOPLE = 1024;
  localparam int IDX_W      = $clog2(MAX_PEOPLE);
  localparam int CNT_W      = 11;
  localparam int PROB_W     = 16;
  localparam int ESC_W      = 32;
  localparam int CFG_W      = 32;
  localparam int REG_IDX_W  = 2;
  localparam int BIT_CNT_W  = $clog2(CNT_W);

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_VISIT = 2'd1;
  localparam logic [1:0] FUNC_SEED  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_POPULATION = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RECOVERY   = 2'd2;

  localparam logic [CNT_W-1:0]  POPULATION_RST = 11'd1000;
  localparam logic [ESC_W-1:0]  ESCAPE_RST     = 32'd4294795496;
  localparam logic [PROB_W-1:0] RECOVERY_RST   = 16'd1298;

  typedef enum logic [1:0] {
    PS_SUS = 2'd0,
    PS_INF = 2'd1,
    PS_REC = 2'd2,
    PS_BAD = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_POW
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_MUL_ACC,
    PH_UPD_ACC,
    PH_MUL_SQ,
    PH_UPD_SQ
  } pow_phase_t;

  typedef struct packed {
    logic              done;
    logic [PROB_W-1:0] prob;
  } pow_rsp_t;

endpackage

// ===== hw/rtl/epid_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module epid_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/epid_pow.sv =====
// Iterative square-and-multiply unit that forms 1 - base^n in Q0.16 from a Q0.32 base.
// Shared 32x32 multiplier; per bit: mul/upd acc, then mul/upd sq. Depends on epid_pkg.
module epid_pow (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [epid_pkg::ESC_W-1:0] base,
  input  logic [epid_pkg::CNT_W-1:0] n,
  output epid_pkg::pow_rsp_t        rsp
);
  import epid_pkg::*;

  logic                 busy;
  pow_phase_t           phase;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [CNT_W-1:0]     n_sh;
  logic [ESC_W-1:0]     acc;
  logic [ESC_W-1:0]     sq;
  logic                 is_one;
  logic [2*ESC_W-1:0]   prod;
  logic [2*ESC_W-1:0]   rsum;
  logic [ESC_W-1:0]     rnd;
  logic [ESC_W:0]       p33;
  logic [ESC_W:0]       p_rnd;
  logic [PROB_W-1:0]    prob_final;
  logic                 last;

  always_comb begin
    rsum  = prod + {{ESC_W{1'b0}}, 1'b1, {(ESC_W-1){1'b0}}};
    rnd   = rsum[2*ESC_W-1:ESC_W];
    p33   = {1'b1, {ESC_W{1'b0}}} - {1'b0, acc};
    p_rnd = p33 + (ESC_W+1)'(1 << (PROB_W-1));
    if (is_one) begin
      prob_final = '0;
    end else if (p_rnd[ESC_W:PROB_W] > (ESC_W+1-PROB_W)'({PROB_W{1'b1}})) begin
      prob_final = {PROB_W{1'b1}};
    end else begin
      prob_final = p_rnd[PROB_W+PROB_W-1:PROB_W];
    end
    last = (bit_cnt == BIT_CNT_W'(CNT_W-1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
      phase    <= PH_MUL_ACC;
    end else begin
      rsp.done <= 1'b0;
      if (start && !busy) begin
        busy    <= 1'b1;
        phase   <= PH_MUL_ACC;
        bit_cnt <= '0;
        n_sh    <= n;
        sq      <= base;
        acc     <= '0;
        is_one  <= 1'b1;
      end else if (busy) begin
        unique case (phase)
          PH_MUL_ACC: begin
            prod  <= {{ESC_W{1'b0}}, acc} * {{ESC_W{1'b0}}, sq};
            phase <= PH_UPD_ACC;
          end
          PH_UPD_ACC: begin
            if (n_sh[0]) begin
              acc    <= is_one ? sq : rnd;
              is_one <= 1'b0;
            end
            phase <= PH_MUL_SQ;
          end
          PH_MUL_SQ: begin
            prod  <= {{ESC_W{1'b0}}, sq} * {{ESC_W{1'b0}}, sq};
            phase <= PH_UPD_SQ;
          end
          PH_UPD_SQ: begin
            sq      <= rnd;
            n_sh    <= n_sh >> 1;
            bit_cnt <= bit_cnt + 1'b1;
            phase   <= PH_MUL_ACC;
            if (last) begin
              busy     <= 1'b0;
              rsp.done <= 1'b1;
              rsp.prob <= prob_final;
            end
          end
          default: phase <= PH_MUL_ACC;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/sir_individual_epidemic_step.sv =====
// Individual-based SIR epidemic step: status RAM read-modify-write plus counters.
// Visit and seed transactions read the RAM on acceptance, then write back in ST_RMW.
// A tick transaction presents its counts in the cycle after acceptance; the input then stays
// blocked while the shared multiplier forms the infection probability.
// After reset a clearing pass writes all 1024 status entries with in_ready low.
// Depends on epid_pkg, epid_ram and epid_pow.
module sir_individual_epidemic_step (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      func,
  input  logic [epid_pkg::IDX_W-1:0]      person_index,
  input  logic [epid_pkg::PROB_W-1:0]     draw_infect,
  input  logic [epid_pkg::PROB_W-1:0]     draw_recover,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [epid_pkg::CNT_W-1:0]      susceptible_total,
  output logic [epid_pkg::CNT_W-1:0]      infected_total,
  output logic [epid_pkg::CNT_W-1:0]      recovered_total,
  input  logic                            cfg_we,
  input  logic [epid_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [epid_pkg::CFG_W-1:0]      cfg_data
);
  import epid_pkg::*;

  ctrl_state_t       state;
  ctrl_state_t       state_next;
  logic [IDX_W-1:0]  clear_cnt;

  logic [CNT_W-1:0]  population;
  logic [ESC_W-1:0]  escape_per_infected;
  logic [PROB_W-1:0] recovery_probability;
  logic [PROB_W-1:0] infection_probability;
  logic [CNT_W-1:0]  infected_count;
  logic [CNT_W-1:0]  recovered_count;

  logic [1:0]        func_q;
  logic [IDX_W-1:0]  idx_q;
  logic              ok_q;
  logic [PROB_W-1:0] dinf_q;
  logic [PROB_W-1:0] drec_q;

  logic              accept;
  logic              idx_ok;
  logic              pow_start;
  pow_rsp_t          pow_rsp;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [1:0]        ram_wdata;
  logic [1:0]        ram_rdata;

  logic              inf_hit;
  logic              rec_hit;
  status_t           new_status;
  logic [CNT_W:0]    used;
  logic [CNT_W-1:0]  sus;

  epid_ram #(
    .WIDTH(2),
    .DEPTH(MAX_PEOPLE)
  ) u_status_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(person_index),
    .rdata(ram_rdata)
  );

  epid_pow u_pow (
    .clk  (clk),
    .rst  (rst),
    .start(pow_start),
    .base (escape_per_infected),
    .n    (infected_count),
    .rsp  (pow_rsp)
  );

  always_comb begin
    status_t cur;
    status_t mid;
    cur = status_t'(ram_rdata);
    idx_ok = ({1'b0, person_index} < population);
    in_ready = (state == ST_IDLE) && !(func == FUNC_TICK && out_valid && !out_ready);
    accept = in_valid && in_ready;
    pow_start = accept && (func == FUNC_TICK);

    inf_hit = 1'b0;
    if (func_q == FUNC_VISIT) begin
      inf_hit = (cur == PS_SUS) && (dinf_q < infection_probability);
    end else if (func_q == FUNC_SEED) begin
      inf_hit = (cur == PS_SUS);
    end
    mid = inf_hit ? PS_INF : cur;
    rec_hit = (func_q == FUNC_VISIT) && (mid == PS_INF) && (drec_q < recovery_probability);
    new_status = rec_hit ? PS_REC : mid;

    used = {1'b0, infected_count} + {1'b0, recovered_count};
    sus = ({1'b0, population} > used) ? (population - used[CNT_W-1:0]) : '0;

    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = new_status;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_cnt;
        ram_wdata = PS_SUS;
        if (clear_cnt == {IDX_W{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (func == FUNC_VISIT || func == FUNC_SEED) begin
            state_next = ST_RMW;
          end else if (func == FUNC_TICK) begin
            state_next = ST_POW;
          end
        end
      end
      ST_RMW: begin
        ram_we     = ok_q;
        state_next = ST_IDLE;
      end
      ST_POW: begin
        if (pow_rsp.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt             <= '0;
      population            <= POPULATION_RST;
      escape_per_infected   <= ESCAPE_RST;
      recovery_probability  <= RECOVERY_RST;
      infection_probability <= '0;
      infected_count        <= '0;
      recovered_count       <= '0;
      out_valid             <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clear_cnt <= clear_cnt + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POPULATION: population           <= cfg_data[CNT_W-1:0];
          REG_ESCAPE:     escape_per_infected  <= cfg_data[ESC_W-1:0];
          REG_RECOVERY:   recovery_probability <= cfg_data[PROB_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_RMW && ok_q) begin
        infected_count  <= infected_count + CNT_W'(inf_hit) - CNT_W'(rec_hit);
        recovered_count <= recovered_count + CNT_W'(rec_hit);
      end
      if (state == ST_POW && pow_rsp.done) begin
        infection_probability <= pow_rsp.prob;
      end
      if (pow_start) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      idx_q  <= person_index;
      ok_q   <= idx_ok;
      dinf_q <= draw_infect;
      drec_q <= draw_recover;
    end
    if (pow_start) begin
      susceptible_total <= sus;
      infected_total    <= infected_count;
      recovered_total   <= recovered_count;
    end
  end

endmodule
